FILE: rtl/vtlsu_pkg.sv
`timescale 1ns / 1ps
// Package for the floating-point register transfer and load/store unit.
// Holds the transfer types, field codes, sizes and index helpers; no dependencies.
package vtlsu_pkg;

    localparam int REG_COUNT      = 32;
    localparam int MAX_LIST_WORDS = 32;
    localparam int IDX_W          = $clog2(REG_COUNT);
    localparam int CNT_W          = 6;

    localparam logic [IDX_W-1:0] REG_LAST = IDX_W'(REG_COUNT - 1);

    // Input item kinds.
    localparam logic [2:0] KIND_READ   = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_LOAD   = 3'd2;
    localparam logic [2:0] KIND_STORE  = 3'd3;
    localparam logic [2:0] KIND_RETURN = 3'd4;

    // Result kinds.
    localparam logic [2:0] RK_DONE      = 3'd0;
    localparam logic [2:0] RK_READ      = 3'd1;
    localparam logic [2:0] RK_MEMRD     = 3'd2;
    localparam logic [2:0] RK_MEMWR     = 3'd3;
    localparam logic [2:0] RK_WBACK     = 3'd4;
    localparam logic [2:0] RK_UNDEF     = 3'd5;
    localparam logic [2:0] RK_FLAGS     = 3'd6;
    localparam logic [2:0] RK_UNHANDLED = 3'd7;

    // Transfer opcodes and system register numbers.
    localparam logic [3:0] OP_SINGLE  = 4'd0;
    localparam logic [3:0] OP_SYSTEM  = 4'd7;
    localparam logic [4:0] SYS_ID     = 5'h00;
    localparam logic [4:0] SYS_EXC    = 5'h10;
    localparam logic [4:0] SYS_STATUS = 5'h02;

    // Memory addressing modes, P,U,W.
    localparam logic [2:0] MODE_IA    = 3'd2;
    localparam logic [2:0] MODE_IA_WB = 3'd3;
    localparam logic [2:0] MODE_NEG   = 3'd4;
    localparam logic [2:0] MODE_DB_WB = 3'd5;
    localparam logic [2:0] MODE_POS   = 3'd6;

    localparam logic [31:0] ID_VALUE   = 32'h410120B4;
    localparam logic [31:0] FLAG_MASK  = 32'hF0000000;
    localparam int          ENABLE_POS = 30;

    typedef struct packed {
        logic [2:0]  kind;
        logic        double_variant;
        logic [3:0]  opcode_bits;
        logic [3:0]  reg_n_field;
        logic [3:0]  reg_d_field;
        logic [2:0]  sub_opcode;
        logic [7:0]  word_offset;
        logic [31:0] base_address;
        logic [31:0] core_data;
        logic        dest_is_pc;
    } t_in;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] value;
        logic [31:0] address;
        logic        last;
    } t_out;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    // Reduces a register number below twice the register count.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [5:0] x);
        logic [6:0] t;
        t = {1'b0, x};
        if (t >= 7'(REG_COUNT)) begin
            t = t - 7'(REG_COUNT);
        end
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] p);
        return (p == REG_LAST) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: rtl/vtlsu_ram.sv
`timescale 1ns / 1ps
// Floating register file: one write port, one registered read port.
// Depends on vtlsu_pkg for sizes and the request struct.
module vtlsu_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vtlsu_pkg::t_ram_req i_req,
    output logic [31:0]       o_rdata
);
    import vtlsu_pkg::*;

    logic [31:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [31:0]          r_rdata;

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_valid[i_req.raddr] ? r_mem[i_req.raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/vfp_transfer_load_store_unit_top.sv
`timescale 1ns / 1ps
// Top level of the floating-point register transfer and load/store unit.
// Depends on vtlsu_pkg and the register file vtlsu_ram.
//
// Usage: the core offers one item per transfer on the input channel
// (i_in_valid / o_in_ready, payload i_in): a register read or write, a load
// or store instruction, or a word that memory returns for an earlier load.
// Each item yields one or more results on the output channel (o_out_valid /
// i_out_ready, payload o_out); the final result of an item carries last.
// Items are handled one at a time. An item is taken only while the unit is
// idle, and the register file read is started in that same cycle. A
// single-result item is decoded in the following cycle, and its result is
// loaded into the output register at the end of that decode cycle when the
// output register is free. A load or store list is decoded the same way;
// after the decode cycle the sequencer emits one memory request per cycle
// while the receiver takes them, followed by a base writeback result if the
// mode has one, each store word coming from the one read port of the
// register file, read ahead of the request that sends it.
// The output register lets the next result be prepared while the last one
// waits; when the receiver stalls, the sequencer holds its state and the
// register file read data until the output register frees up.
// Synchronous reset clears the registers to zero (through per-entry valid
// bits), disables the unit and drops any pending load words.
module vfp_transfer_load_store_unit_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  vtlsu_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output vtlsu_pkg::t_out o_out
);
    import vtlsu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_WORDS = 4'b0100,
        S_WBACK = 4'b1000
    } t_state;

    // Control state.
    t_state           r_state, n_state;
    logic             r_out_valid;
    logic [31:0]      r_exc, n_exc;
    logic [31:0]      r_status, n_status;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_pending, n_pending;

    // Payload and sequencer working registers.
    t_in              r_in;
    t_out             r_out, n_out;
    logic             n_emit;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_addr, n_addr;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic             r_wb, n_wb;
    logic             r_is_load, n_is_load;
    logic [31:0]      r_newbase, n_newbase;

    t_ram_req    w_req;
    logic [31:0] w_rdata;
    logic        w_accept;
    logic        w_load_out;

    // Decoded fields of the held item.
    logic [4:0]       w_sn;
    logic [IDX_W-1:0] w_sn_idx;
    logic [2:0]       w_mode;
    logic [IDX_W-1:0] w_fd_idx;
    logic             w_en;
    logic [31:0]      w_ofs4;
    logic             w_is_read;
    logic             w_is_load;

    vtlsu_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load_out  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_sn      = {r_in.reg_n_field, r_in.sub_opcode[2]};
    assign w_sn_idx  = wrap_idx({1'b0, w_sn});
    assign w_mode    = {r_in.opcode_bits[3:2], r_in.opcode_bits[0]};
    assign w_fd_idx  = wrap_idx({1'b0, r_in.reg_d_field, r_in.opcode_bits[1]});
    assign w_en      = r_exc[ENABLE_POS];
    assign w_ofs4    = {22'd0, r_in.word_offset, 2'b00};
    assign w_is_read = (r_in.kind == KIND_READ);
    assign w_is_load = (r_in.kind == KIND_LOAD);

    always_comb begin
        logic [31:0]      start;
        logic [CNT_W-1:0] words;
        logic             wb;
        logic [31:0]      newbase;

        n_state   = r_state;
        n_exc     = r_exc;
        n_status  = r_status;
        n_fill    = r_fill;
        n_pending = r_pending;
        n_cnt     = r_cnt;
        n_addr    = r_addr;
        n_ptr     = r_ptr;
        n_wb      = r_wb;
        n_is_load = r_is_load;
        n_newbase = r_newbase;
        n_emit    = 1'b0;
        n_out     = '0;
        w_req     = '0;
        start     = '0;
        words     = '0;
        wb        = 1'b0;
        newbase   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state     = S_EXEC;
                    w_req.re    = 1'b1;
                    w_req.raddr = (i_in.kind == KIND_STORE)
                        ? wrap_idx({1'b0, i_in.reg_d_field, i_in.opcode_bits[1]})
                        : wrap_idx({1'b0, i_in.reg_n_field, i_in.sub_opcode[2]});
                end
            end

            S_EXEC: begin
                if (w_load_out) begin
                    n_emit            = 1'b1;
                    n_out.last        = 1'b1;
                    n_out.result_kind = RK_UNHANDLED;
                    n_state           = S_IDLE;

                    if (r_in.kind == KIND_READ || r_in.kind == KIND_WRITE) begin
                        if (r_in.double_variant) begin
                            n_out.result_kind = RK_UNHANDLED;
                        end else if (r_in.opcode_bits == OP_SINGLE) begin
                            if (!w_en) begin
                                n_out.result_kind = RK_UNDEF;
                            end else if (w_is_read) begin
                                n_out.result_kind = RK_READ;
                                n_out.value       = w_rdata;
                            end else begin
                                n_out.result_kind = RK_DONE;
                                w_req.we          = 1'b1;
                                w_req.waddr       = w_sn_idx;
                                w_req.wdata       = r_in.core_data;
                            end
                        end else if (r_in.opcode_bits == OP_SYSTEM) begin
                            if (w_sn == SYS_ID && w_is_read) begin
                                n_out.result_kind = RK_READ;
                                n_out.value       = ID_VALUE;
                            end else if (w_sn == SYS_EXC) begin
                                if (w_is_read) begin
                                    n_out.result_kind = RK_READ;
                                    n_out.value       = r_exc;
                                end else begin
                                    n_out.result_kind = RK_DONE;
                                    n_exc             = r_in.core_data;
                                end
                            end else if (w_sn == SYS_STATUS) begin
                                if (!w_en) begin
                                    n_out.result_kind = RK_UNDEF;
                                end else if (!w_is_read) begin
                                    n_out.result_kind = RK_DONE;
                                    n_status          = r_in.core_data;
                                end else if (r_in.dest_is_pc) begin
                                    n_out.result_kind = RK_FLAGS;
                                    n_out.value       = r_status & FLAG_MASK;
                                end else begin
                                    n_out.result_kind = RK_READ;
                                    n_out.value       = r_status;
                                end
                            end
                        end
                    end else if (r_in.kind == KIND_LOAD || r_in.kind == KIND_STORE) begin
                        if (!(w_mode inside {MODE_IA, MODE_IA_WB, MODE_NEG,
                                             MODE_DB_WB, MODE_POS})) begin
                            n_out.result_kind = RK_UNHANDLED;
                        end else if (!w_en) begin
                            n_out.result_kind = RK_UNDEF;
                        end else if ((w_mode == MODE_IA || w_mode == MODE_IA_WB
                                      || w_mode == MODE_DB_WB)
                                     && (int'(r_in.word_offset) > MAX_LIST_WORDS)) begin
                            n_out.result_kind = RK_UNHANDLED;
                        end else begin
                            if (w_mode == MODE_NEG || w_mode == MODE_POS) begin
                                start = (w_mode == MODE_POS)
                                    ? r_in.base_address + w_ofs4
                                    : r_in.base_address - w_ofs4;
                                words = r_in.double_variant ? CNT_W'(2) : CNT_W'(1);
                            end else begin
                                words = r_in.word_offset[CNT_W-1:0];
                                wb    = (w_mode != MODE_IA);
                                if (w_mode == MODE_DB_WB) begin
                                    newbase = r_in.base_address - w_ofs4;
                                    start   = newbase;
                                end else begin
                                    newbase = r_in.base_address + w_ofs4;
                                    start   = r_in.base_address;
                                end
                            end

                            if (w_is_load) begin
                                n_fill    = w_fd_idx;
                                n_pending = words;
                            end

                            if (words != '0) begin
                                // Hand the list to the word sequencer.
                                n_emit    = 1'b0;
                                n_state   = S_WORDS;
                                n_cnt     = words;
                                n_addr    = start;
                                n_ptr     = w_fd_idx;
                                n_wb      = wb;
                                n_is_load = w_is_load;
                                n_newbase = newbase;
                            end else if (wb) begin
                                n_out.result_kind = RK_WBACK;
                                n_out.value       = newbase;
                            end else begin
                                n_out.result_kind = RK_DONE;
                            end
                        end
                    end else if (r_in.kind == KIND_RETURN) begin
                        n_out.result_kind = RK_DONE;
                        if (r_pending != '0) begin
                            w_req.we    = 1'b1;
                            w_req.waddr = r_fill;
                            w_req.wdata = r_in.core_data;
                            n_fill      = inc_idx(r_fill);
                            n_pending   = r_pending - 1'b1;
                        end
                    end
                end
            end

            S_WORDS: begin
                if (w_load_out) begin
                    n_emit            = 1'b1;
                    n_out.result_kind = r_is_load ? RK_MEMRD : RK_MEMWR;
                    n_out.value       = r_is_load ? '0 : w_rdata;
                    n_out.address     = r_addr;
                    n_out.last        = (r_cnt == CNT_W'(1)) && !r_wb;
                    // Read the next store word ahead of its cycle.
                    w_req.re          = !r_is_load;
                    w_req.raddr       = inc_idx(r_ptr);
                    n_ptr             = inc_idx(r_ptr);
                    n_addr            = r_addr + 32'd4;
                    n_cnt             = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = r_wb ? S_WBACK : S_IDLE;
                    end
                end
            end

            S_WBACK: begin
                if (w_load_out) begin
                    n_emit            = 1'b1;
                    n_out.result_kind = RK_WBACK;
                    n_out.value       = r_newbase;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_exc       <= '0;
            r_status    <= '0;
            r_fill      <= '0;
            r_pending   <= '0;
        end else begin
            r_state   <= n_state;
            r_exc     <= n_exc;
            r_status  <= n_status;
            r_fill    <= n_fill;
            r_pending <= n_pending;
            if (w_load_out) begin
                r_out_valid <= n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
        if (w_load_out && n_emit) begin
            r_out <= n_out;
        end
        r_cnt     <= n_cnt;
        r_addr    <= n_addr;
        r_ptr     <= n_ptr;
        r_wb      <= n_wb;
        r_is_load <= n_is_load;
        r_newbase <= n_newbase;
    end

endmodule
